// ----- rtl/mex_pkg.sv -----
// shared types, constants and microcode table of the modular exponentiation core
// depends on nothing; every other file takes names from here by scope

package mex_pkg;

   // item field width, fixed by the channel format
   localparam int FIELD_WIDTH = 32;

   // defaults for the top level parameters
   localparam int DEFAULT_OPERAND_WIDTH  = 32;
   localparam int DEFAULT_EXPONENT_WIDTH = 32;

   // sequencer program counter
   localparam int PC_WIDTH = 4;

   // jump conditions
   localparam logic [2:0] COND_NONE        = 3'd0;
   localparam logic [2:0] COND_NO_REQ      = 3'd1;
   localparam logic [2:0] COND_EXP_ZERO    = 3'd2;
   localparam logic [2:0] COND_BIT_CLEAR   = 3'd3;
   localparam logic [2:0] COND_BUSY        = 3'd4;
   localparam logic [2:0] COND_EXP_NONZERO = 3'd5;
   localparam logic [2:0] COND_RSP_FULL    = 3'd6;

   // multiplier operand selects
   localparam logic ASEL_ACC  = 1'b0;
   localparam logic ASEL_BASE = 1'b1;
   localparam logic BSEL_BASE = 1'b0;
   localparam logic BSEL_ONE  = 1'b1;

   // write-back destinations
   localparam logic [1:0] DEST_NONE = 2'd0;
   localparam logic [1:0] DEST_BASE = 2'd1;
   localparam logic [1:0] DEST_ACC  = 2'd2;

   // program steps
   localparam logic [PC_WIDTH-1:0] STEP_IDLE  = 4'd0;
   localparam logic [PC_WIDTH-1:0] STEP_ZCHK  = 4'd1;
   localparam logic [PC_WIDTH-1:0] STEP_RBASE = 4'd2;
   localparam logic [PC_WIDTH-1:0] STEP_WAITB = 4'd3;
   localparam logic [PC_WIDTH-1:0] STEP_TEST  = 4'd4;
   localparam logic [PC_WIDTH-1:0] STEP_MUL   = 4'd5;
   localparam logic [PC_WIDTH-1:0] STEP_WAITM = 4'd6;
   localparam logic [PC_WIDTH-1:0] STEP_SQ    = 4'd7;
   localparam logic [PC_WIDTH-1:0] STEP_WAITS = 4'd8;
   localparam logic [PC_WIDTH-1:0] STEP_LOOP  = 4'd9;
   localparam logic [PC_WIDTH-1:0] STEP_DONE  = 4'd10;

   // one control word; actions fire only when the jump is not taken
   typedef struct packed {
      logic [2:0]          cond;
      logic [PC_WIDTH-1:0] target;
      logic                last;
      logic                start;
      logic                a_sel;
      logic                b_sel;
      logic [1:0]          dest;
      logic                shift_exp;
      logic                load_req;
      logic                fire_rsp;
   } uop_type;

   typedef struct packed {
      uop_type uop;
      logic    act;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic unit_done;
      logic exp_zero;
      logic exp_bit0;
      logic rsp_full;
   } status_type;

   function automatic uop_type uop_make(input logic [2:0] cond,
                                        input logic [PC_WIDTH-1:0] target,
                                        input logic last, input logic start,
                                        input logic a_sel, input logic b_sel,
                                        input logic [1:0] dest, input logic shift_exp,
                                        input logic load_req, input logic fire_rsp);
      uop_type u;
      u.cond      = cond;
      u.target    = target;
      u.last      = last;
      u.start     = start;
      u.a_sel     = a_sel;
      u.b_sel     = b_sel;
      u.dest      = dest;
      u.shift_exp = shift_exp;
      u.load_req  = load_req;
      u.fire_rsp  = fire_rsp;
      return u;
   endfunction

   // microcode rom
   function automatic uop_type rom_read(input logic [PC_WIDTH-1:0] pc);
      uop_type u;
      case (pc)
         STEP_IDLE: begin
            u = uop_make(COND_NO_REQ, STEP_IDLE, 1'b0, 1'b0, ASEL_ACC, BSEL_BASE,
                         DEST_NONE, 1'b0, 1'b1, 1'b0);
         end
         STEP_ZCHK: begin
            u = uop_make(COND_EXP_ZERO, STEP_DONE, 1'b0, 1'b0, ASEL_ACC, BSEL_BASE,
                         DEST_NONE, 1'b0, 1'b0, 1'b0);
         end
         STEP_RBASE: begin
            u = uop_make(COND_NONE, STEP_IDLE, 1'b0, 1'b1, ASEL_BASE, BSEL_ONE,
                         DEST_NONE, 1'b0, 1'b0, 1'b0);
         end
         STEP_WAITB: begin
            u = uop_make(COND_BUSY, STEP_WAITB, 1'b0, 1'b0, ASEL_ACC, BSEL_BASE,
                         DEST_BASE, 1'b0, 1'b0, 1'b0);
         end
         STEP_TEST: begin
            u = uop_make(COND_BIT_CLEAR, STEP_SQ, 1'b0, 1'b0, ASEL_ACC, BSEL_BASE,
                         DEST_NONE, 1'b0, 1'b0, 1'b0);
         end
         STEP_MUL: begin
            u = uop_make(COND_NONE, STEP_IDLE, 1'b0, 1'b1, ASEL_ACC, BSEL_BASE,
                         DEST_NONE, 1'b0, 1'b0, 1'b0);
         end
         STEP_WAITM: begin
            u = uop_make(COND_BUSY, STEP_WAITM, 1'b0, 1'b0, ASEL_ACC, BSEL_BASE,
                         DEST_ACC, 1'b0, 1'b0, 1'b0);
         end
         STEP_SQ: begin
            u = uop_make(COND_NONE, STEP_IDLE, 1'b0, 1'b1, ASEL_BASE, BSEL_BASE,
                         DEST_NONE, 1'b0, 1'b0, 1'b0);
         end
         STEP_WAITS: begin
            u = uop_make(COND_BUSY, STEP_WAITS, 1'b0, 1'b0, ASEL_ACC, BSEL_BASE,
                         DEST_BASE, 1'b1, 1'b0, 1'b0);
         end
         STEP_LOOP: begin
            u = uop_make(COND_EXP_NONZERO, STEP_TEST, 1'b0, 1'b0, ASEL_ACC, BSEL_BASE,
                         DEST_NONE, 1'b0, 1'b0, 1'b0);
         end
         STEP_DONE: begin
            u = uop_make(COND_RSP_FULL, STEP_DONE, 1'b1, 1'b0, ASEL_ACC, BSEL_BASE,
                         DEST_NONE, 1'b0, 1'b0, 1'b1);
         end
         default: begin
            u = uop_make(COND_NONE, STEP_IDLE, 1'b1, 1'b0, ASEL_ACC, BSEL_BASE,
                         DEST_NONE, 1'b0, 1'b0, 1'b0);
         end
      endcase
      return u;
   endfunction

endpackage

// ----- rtl/mex_if.sv -----
// valid/ready channel interfaces for request and response items
// depends on mex_pkg for the field width

interface mex_req_if;
   logic                             valid;
   logic                             ready;
   logic [mex_pkg::FIELD_WIDTH-1:0]  base_value;
   logic [mex_pkg::FIELD_WIDTH-1:0]  exponent;

   modport source (output valid, output base_value, output exponent, input ready);
   modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

interface mex_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mex_pkg::FIELD_WIDTH-1:0]  power_result;

   modport source (output valid, output power_result, input ready);
   modport sink   (input valid, input power_result, output ready);
endinterface

// ----- rtl/mex_mulmod.sv -----
// modular multiply unit: registered product, then restoring reduction one bit a cycle
// depends on mex_pkg for the default operand width

module mex_mulmod #(
   parameter int OPERAND_WIDTH = mex_pkg::DEFAULT_OPERAND_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [OPERAND_WIDTH-1:0] op_a,
   input  logic [OPERAND_WIDTH-1:0] op_b,
   input  logic [OPERAND_WIDTH-1:0] modulus,
   output logic                     done,
   output logic [OPERAND_WIDTH-1:0] result
);

   localparam int OW = OPERAND_WIDTH;
   localparam int PW = 2 * OPERAND_WIDTH;
   localparam int CW = $clog2(PW);
   localparam logic [CW-1:0] LAST_STEP = CW'(PW - 1);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_REDUCE = 1'b1;

   logic          state_ff, state_in;
   logic [PW-1:0] product_ff, product_in;
   logic [OW-1:0] rem_ff, rem_in;
   logic [CW-1:0] count_ff, count_in;
   logic          done_ff, done_in;
   logic [OW-1:0] result_ff, result_in;

   logic [OW:0]   rem_shift;
   logic [OW:0]   mod_ext;
   logic [OW:0]   rem_sub;
   logic [OW-1:0] rem_next;
   logic [PW-1:0] product;

   assign product   = PW'(op_a) * PW'(op_b);
   assign rem_shift = {rem_ff, product_ff[PW-1]};
   assign mod_ext   = {1'b0, modulus};
   assign rem_sub   = rem_shift - mod_ext;
   assign rem_next  = (rem_shift >= mod_ext) ? rem_sub[OW-1:0] : rem_shift[OW-1:0];

   always_comb begin
      state_in   = state_ff;
      product_in = product_ff;
      rem_in     = rem_ff;
      count_in   = count_ff;
      done_in    = 1'b0;
      result_in  = result_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               product_in = product;
               rem_in     = '0;
               count_in   = '0;
               state_in   = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (modulus == '0) begin
               // zero modulus: plain wrap to the operand width
               done_in   = 1'b1;
               result_in = product_ff[OW-1:0];
               state_in  = ST_IDLE;
            end else begin
               product_in = product_ff << 1;
               rem_in     = rem_next;
               count_in   = count_ff + 1'b1;
               if (count_ff == LAST_STEP) begin
                  done_in   = 1'b1;
                  result_in = rem_next;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      product_ff <= product_in;
      rem_ff     <= rem_in;
      count_ff   <= count_in;
      result_ff  <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ----- rtl/mex_sequencer.sv -----
// microcode sequencer: program counter, rom lookup and conditional jumps
// depends on mex_pkg for the control word, status group and rom

module mex_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  mex_pkg::status_type status,
   output mex_pkg::ctrl_type   ctrl
);

   logic [mex_pkg::PC_WIDTH-1:0] pc_ff, pc_in;
   mex_pkg::uop_type             uop;
   logic                         jump;

   assign uop = mex_pkg::rom_read(pc_ff);

   always_comb begin
      case (uop.cond)
         mex_pkg::COND_NONE:        jump = 1'b0;
         mex_pkg::COND_NO_REQ:      jump = !status.req_valid;
         mex_pkg::COND_EXP_ZERO:    jump = status.exp_zero;
         mex_pkg::COND_BIT_CLEAR:   jump = !status.exp_bit0;
         mex_pkg::COND_BUSY:        jump = !status.unit_done;
         mex_pkg::COND_EXP_NONZERO: jump = !status.exp_zero;
         mex_pkg::COND_RSP_FULL:    jump = status.rsp_full;
         default:                   jump = 1'b0;
      endcase
   end

   always_comb begin
      if (jump) begin
         pc_in = uop.target;
      end else if (uop.last) begin
         pc_in = mex_pkg::STEP_IDLE;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= mex_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.uop = uop;
   assign ctrl.act = !jump;

endmodule

// ----- rtl/modular_exponentiation_core.sv -----
// top level of the modular exponentiation core: datapath registers, handshakes, csr
// depends on mex_pkg, mex_if, mex_mulmod and mex_sequencer

// computes base_value ** exponent mod modulus by right-to-left square-and-multiply.
// the modulus is a csr that must be written while the core is idle; the block does
// not enforce this. it resets to 1, and only its low OPERAND_WIDTH bits count (a
// modulus of zero makes every product wrap to OPERAND_WIDTH bits). a zero exponent
// returns 1 as is, even for a modulus of 1. one item is worked at a time. every
// modular product goes through the shared multiply unit: a registered multiply,
// then bit-serial restoring reduction. a finished result sits in an output
// register, so the next item is taken while the previous result still waits to
// be collected.

module modular_exponentiation_core #(
   parameter int OPERAND_WIDTH  = mex_pkg::DEFAULT_OPERAND_WIDTH,
   parameter int EXPONENT_WIDTH = mex_pkg::DEFAULT_EXPONENT_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   mex_req_if.sink                         req_chan,
   mex_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_enable,
   input  logic [mex_pkg::FIELD_WIDTH-1:0] csr_write_data
);

   localparam int OW = OPERAND_WIDTH;
   localparam int FW = mex_pkg::FIELD_WIDTH;
   // exponent bits that can actually arrive on the 32-bit field
   localparam int EXP_BITS = (EXPONENT_WIDTH < FW) ? EXPONENT_WIDTH : FW;

   // csr: modulus, reset to 1
   logic [OW-1:0] modulus_ff;

   // datapath registers
   logic [OW-1:0]       base_ff;
   logic [OW-1:0]       acc_ff;
   logic [EXP_BITS-1:0] exp_ff;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0] rsp_result_ff;

   mex_pkg::ctrl_type   ctrl;
   mex_pkg::status_type status;

   logic [OW-1:0] op_a;
   logic [OW-1:0] op_b;
   logic          mm_start;
   logic          mm_done;
   logic [OW-1:0] mm_result;

   logic          load_en;
   logic          wr_base;
   logic          wr_acc;
   logic          shift_en;
   logic          fire_en;
   logic          rsp_full;

   // ---- sequencer ----
   mex_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // output slot is busy only if the held item is not leaving this cycle
   assign rsp_full = rsp_valid_ff && !rsp_chan.ready;

   assign status.req_valid = req_chan.valid;
   assign status.unit_done = mm_done;
   assign status.exp_zero  = (exp_ff == '0);
   assign status.exp_bit0  = exp_ff[0];
   assign status.rsp_full  = rsp_full;

   // ready only in the idle step, the one step that waits for an item
   assign req_chan.ready = (ctrl.uop.cond == mex_pkg::COND_NO_REQ);

   // actions of the current step, qualified by "jump not taken"
   assign load_en  = ctrl.act && ctrl.uop.load_req;
   assign mm_start = ctrl.act && ctrl.uop.start;
   assign wr_base  = ctrl.act && (ctrl.uop.dest == mex_pkg::DEST_BASE);
   assign wr_acc   = ctrl.act && (ctrl.uop.dest == mex_pkg::DEST_ACC);
   assign shift_en = ctrl.act && ctrl.uop.shift_exp;
   assign fire_en  = ctrl.act && ctrl.uop.fire_rsp;

   // ---- multiplier operand selection ----
   assign op_a = (ctrl.uop.a_sel == mex_pkg::ASEL_ACC) ? acc_ff : base_ff;
   assign op_b = (ctrl.uop.b_sel == mex_pkg::BSEL_ONE) ? OW'(1) : base_ff;

   mex_mulmod #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .op_a    (op_a),
      .op_b    (op_b),
      .modulus (modulus_ff),
      .done    (mm_done),
      .result  (mm_result)
   );

   // ---- csr ----
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= OW'(1);
      end else if (csr_write_enable) begin
         modulus_ff <= csr_write_data[OW-1:0];
      end
   end

   // ---- datapath registers ----
   always_ff @(posedge clock) begin
      if (load_en) begin
         // raw base; the first product (base times one) reduces it
         base_ff <= req_chan.base_value[OW-1:0];
         exp_ff  <= req_chan.exponent[EXP_BITS-1:0];
         acc_ff  <= OW'(1);
      end else begin
         if (wr_base) begin
            base_ff <= mm_result;
         end
         if (wr_acc) begin
            acc_ff <= mm_result;
         end
         if (shift_en) begin
            exp_ff <= exp_ff >> 1;
         end
      end
   end

   // ---- response output register ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire_en) begin
         rsp_result_ff <= FW'(acc_ff);
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.power_result = rsp_result_ff;

   // ---- assertions ----

   // the core is not ready again in the cycle after it takes an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request ready stayed high after an item was taken");

   // the multiply unit only finishes while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mm_done |-> (ctrl.uop.cond == mex_pkg::COND_BUSY))
      else $error("multiply unit finished outside a wait step");

   // a new result never overwrites one still waiting at the output
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      fire_en |-> !(rsp_valid_ff && !rsp_chan.ready))
      else $error("result written over a pending item");

   // squaring only happens while exponent bits remain
   a_shift_nonzero: assert property (@(posedge clock) disable iff (reset)
      shift_en |-> (exp_ff != '0))
      else $error("exponent shifted after it reached zero");

   // no new product starts the cycle after one was started
   a_single_start: assert property (@(posedge clock) disable iff (reset)
      mm_start |=> !mm_start)
      else $error("multiply unit started twice in a row");

endmodule

// ----- tb/modular_exponentiation_core_tb.sv -----
// self-checking testbench of the modular exponentiation core
// depends on mex_pkg, mex_if and modular_exponentiation_core from the rtl

module modular_exponentiation_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // the core is built with its default widths
   localparam int OPERAND_WIDTH  = mex_pkg::DEFAULT_OPERAND_WIDTH;
   localparam int EXPONENT_WIDTH = mex_pkg::DEFAULT_EXPONENT_WIDTH;

   // masks that keep only the bits the core looks at
   localparam bit [63:0] OPERAND_MASK = (OPERAND_WIDTH >= 32) ? 64'hFFFF_FFFF :
                                        (64'd1 << OPERAND_WIDTH) - 64'd1;
   localparam bit [63:0] EXPONENT_MASK = (EXPONENT_WIDTH >= 64) ? {64{1'b1}} :
                                         (64'd1 << EXPONENT_WIDTH) - 64'd1;

   // idle cycles without any handshake before the run is declared hung
   localparam int WATCHDOG_LIMIT = 40000;
   // receiver hold-off that makes the core fill up and stall its input
   localparam int PRESSURE_HOLD  = 3000;
   localparam int RANDOM_PHASES  = 7;
   localparam int PHASE_ITEMS    = 16;
   localparam int PRESSURE_ITEMS = 8;
   // settling time after the last result
   localparam int DRAIN_CYCLES   = 20;

   typedef logic [mex_pkg::FIELD_WIDTH-1:0] word_type;

   // expected powers, predicted from the modulus in force when an item is taken
   class power_scoreboard_type;
      word_type modulus;
      word_type expected_powers[$];
      int       mismatches;

      function new();
         modulus    = 32'd1;
         mismatches = 0;
      endfunction

      function void set_modulus(input word_type value);
         modulus = value;
      endfunction

      // modulus of zero means plain wrap to the operand width
      function bit [63:0] reduce(input bit [63:0] value, input bit [63:0] m);
         if (m == 64'd0)
            return value & OPERAND_MASK;
         return value % m;
      endfunction

      // right-to-left square-and-multiply; a zero exponent gives 1 as is
      function word_type predict_power(input word_type base_value,
                                       input word_type exponent);
         bit [63:0] m;
         bit [63:0] square;
         bit [63:0] bits_left;
         bit [63:0] acc;
         m         = {32'd0, modulus} & OPERAND_MASK;
         square    = reduce({32'd0, base_value} & OPERAND_MASK, m);
         bits_left = {32'd0, exponent} & EXPONENT_MASK;
         acc       = 64'd1;
         while (bits_left != 64'd0) begin
            if (bits_left[0])
               acc = reduce(acc * square, m);
            square    = reduce(square * square, m);
            bits_left = bits_left >> 1;
         end
         return acc[mex_pkg::FIELD_WIDTH-1:0];
      endfunction

      function void note_request(input word_type base_value, input word_type exponent);
         expected_powers.push_back(predict_power(base_value, exponent));
      endfunction

      function void check_result(input word_type power_result);
         word_type want;
         if (expected_powers.size() == 0) begin
            $display("%0t: unexpected power_result, expected none actual %h",
                     $time, power_result);
            mismatches++;
         end else begin
            want = expected_powers.pop_front();
            if (power_result !== want) begin
               $display("%0t: power_result mismatch, expected %h actual %h",
                        $time, want, power_result);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return expected_powers.size();
      endfunction
   endclass

   logic     clock;
   logic     reset;
   logic     csr_write_enable;
   word_type csr_write_data;

   mex_req_if req_bus();
   mex_rsp_if rsp_bus();

   modular_exponentiation_core #(
      .OPERAND_WIDTH  (OPERAND_WIDTH),
      .EXPONENT_WIDTH (EXPONENT_WIDTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   power_scoreboard_type power_board;

   // phase controls shared by the sender and the receiver
   bit no_idle;
   int long_hold_cycles;

   always #5ns clock = ~clock;

   // mostly short gaps, a few long ones, none while a steady phase runs
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 50)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 98)
         return $urandom_range(4, 20);
      return $urandom_range(50, 200);
   endfunction

   // full-range exponents for half the items, short ones for the rest to keep the run moving
   function automatic word_type pick_exponent();
      int kind;
      int width;
      kind  = $urandom_range(0, 9);
      width = $urandom_range(1, 16);
      if (kind < 5)
         return $urandom;
      if (kind < 9)
         return $urandom & ((32'd1 << width) - 32'd1);
      return $urandom_range(0, 3);
   endfunction

   // bases at the extremes and at or just below the modulus as well as anywhere
   function automatic word_type pick_base();
      case ($urandom_range(0, 3))
         0: begin
            return $urandom;
         end
         1: begin
            return $urandom_range(0, 15);
         end
         2: begin
            return power_board.modulus - word_type'($urandom_range(0, 2));
         end
         default: begin
            return 32'hFFFF_FFFF - word_type'($urandom_range(0, 3));
         end
      endcase
   endfunction

   // offer one item after a random gap and hold it until it is taken
   task automatic send_item(input word_type base_value, input word_type exponent);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.base_value <= base_value;
      req_bus.exponent   <= exponent;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // stop offering and wait for every outstanding result
   task automatic close_phase();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (power_board.pending() != 0) @(posedge clock);
   endtask

   // the core is idle here, so the new modulus applies to the next item on
   task automatic write_modulus(input word_type value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      power_board.set_modulus(value);
   endtask

   // receiver: random stalls, and one long hold-off on request
   initial begin
      int stall;
      wait (reset === 1'b0);
      forever begin
         if (long_hold_cycles > 0) begin
            stall            = long_hold_cycles;
            long_hold_cycles = 0;
         end else begin
            stall = pick_gap();
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // check results before noting requests: a result never belongs to the item
   // accepted at the same edge
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         power_board.check_result(rsp_bus.power_result);
      if (!reset && req_bus.valid && req_bus.ready)
         power_board.note_request(req_bus.base_value, req_bus.exponent);
   end

   // watchdog on cycles with no handshake at all
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** modular_exponentiation_core: FAILED **");
      $finish;
   end

   initial begin
      word_type phase_moduli[RANDOM_PHASES];
      // every input known from time zero
      clock              = 1'b0;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.base_value = '0;
      req_bus.exponent   = '0;
      rsp_bus.ready      = 1'b0;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      no_idle            = 1'b0;
      long_hold_cycles   = 0;
      power_board        = new();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // modulus left at its reset value of one: zero exponent still gives 1
      send_item(32'd0, 32'd0);
      send_item(32'd5, 32'd0);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(32'd7, 32'd1);
      close_phase();

      // largest modulus, extreme bases and exponents
      write_modulus(32'hFFFF_FFFF);
      send_item(32'hFFFF_FFFF, 32'd1);
      send_item(32'hFFFF_FFFE, 32'd2);
      send_item(32'd0, 32'd0);
      send_item(32'd0, 32'd5);
      send_item(32'd1, 32'hFFFF_FFFF);
      send_item(32'd2, 32'd31);
      send_item(32'd2, 32'd32);
      send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_item(32'hAAAA_AAAA, 32'h8000_0000);
      close_phase();

      // modulus of zero: products wrap to the operand width
      write_modulus(32'd0);
      send_item(32'd3, 32'd5);
      send_item(32'hFFFF_FFFF, 32'd2);
      send_item(32'd2, 32'd32);
      send_item(32'h8000_0000, 32'd1);
      send_item(32'h5555_5555, 32'h5555_5555);
      close_phase();

      // explicit write of one, then a small prime
      write_modulus(32'd1);
      send_item(32'd9, 32'd0);
      send_item(32'd9, 32'd3);
      close_phase();
      write_modulus(32'd7);
      send_item(32'd3, 32'd6);
      send_item(32'd7, 32'd4);
      close_phase();

      // pressure: receiver holds off while short items keep coming
      write_modulus($urandom);
      long_hold_cycles = PRESSURE_HOLD;
      repeat (PRESSURE_ITEMS) send_item(pick_base(), $urandom & 32'hF);
      close_phase();

      // random phases over several moduli, two of them without idling
      phase_moduli = '{32'hFFFF_FFFB, $urandom, 32'd2, 32'd1, 32'h8000_0000, 32'd0,
                       32'hFFFF_FFFF};
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_modulus(phase_moduli[p]);
         no_idle = (p == 2) || (p == 5);
         repeat (PHASE_ITEMS) send_item(pick_base(), pick_exponent());
         close_phase();
      end
      no_idle = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (power_board.mismatches == 0 && power_board.pending() == 0)
         $display("** modular_exponentiation_core: PASSED **");
      else
         $display("** modular_exponentiation_core: FAILED **");
      $finish;
   end

endmodule
